[src/iad_pkg.sv]
// shared types and constants for the ignition advance delay block
`timescale 1ns / 1ps

package iad_pkg;

    localparam int MAX_SEGMENTS_DEF = 16;

    localparam int IDX_W    = 4;
    localparam int PERIOD_W = 24;
    localparam int COEF_W   = 24;
    localparam int RATIO_W  = 16;
    localparam int DELAY_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // scan counter must reach one past the last 4-bit segment index
    localparam int CNT_W = IDX_W + 1;

    localparam int QUEUE_DEPTH = 2;

    // signed 25x25 product, plus headroom for the offset add
    localparam int MUL_W  = PERIOD_W + 1;
    localparam int PROD_W = 2 * MUL_W;
    localparam int FRAC_W = 20;
    localparam int RATIO_FRAC_W = 16;

    localparam logic OP_COMPUTE = 1'b0;
    localparam logic OP_LOAD    = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SEG_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_RATIO  = 2'd2;

    localparam logic [PERIOD_W-1:0] FLOOR_PERIOD_RST = 24'd60000;

    typedef struct packed {
        logic                       is_load;
        logic [IDX_W-1:0]           index;
        logic [PERIOD_W-1:0]        period;
        logic [PERIOD_W-1:0]        threshold;
        logic signed [COEF_W-1:0]   slope;
        logic signed [COEF_W-1:0]   offset;
    } cmd_t;

    typedef struct packed {
        logic [IDX_W-1:0]    seg_count;
        logic [PERIOD_W-1:0] floor_period;
        logic [RATIO_W-1:0]  floor_ratio;
    } cfg_t;

endpackage

[src/ignition_advance_delay.sv]
// Piecewise linear ignition advance curve: spark delay from engine period.
//
// Input channel (s_valid/s_ready): a load item writes one curve segment
// (threshold, slope Q3.20, offset) at segment_index; a compute item carries
// period_us and yields one result on the m_ channel (delay_us, over_limit).
// Segments are scanned one per cycle from entry 1 up to segment_count; the
// first with threshold <= period is used. Above floor_period the delay is
// period * floor_ratio; with no matching segment delay is 0, over_limit 1.
// The user must write configuration (cfg_we/cfg_index/cfg_data) only while
// the block idles; the block itself does not enforce this.
//
// Flow: a compute passes the front holding register and the queue; the back
// end then reads the single-port segment memory one entry per cycle until a
// match or the last entry, enters its finish state, loads the result register
// and only then takes a new command. Loads retire one per cycle when it idles.
// A two-entry queue lets input transfers continue while the back end works;
// when m_ready is low the result is held and the queue and input stall behind.
// Reset clears configuration to its defaults and empties queue and result;
// the segment table holds nothing until loaded.
`timescale 1ns / 1ps

module ignition_advance_delay import iad_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [IDX_W-1:0]         s_segment_index,
    input  logic [PERIOD_W-1:0]      s_period_us,
    input  logic [PERIOD_W-1:0]      s_seg_threshold,
    input  logic signed [COEF_W-1:0] s_seg_slope,
    input  logic signed [COEF_W-1:0] s_seg_offset,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [DELAY_W-1:0]       m_delay_us,
    output logic                     m_over_limit
);

    cfg_t cfg_reg;
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.seg_count    <= '0;
            cfg_reg.floor_period <= FLOOR_PERIOD_RST;
            cfg_reg.floor_ratio  <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SEG_COUNT:    cfg_reg.seg_count    <= cfg_data[IDX_W-1:0];
                CFG_FLOOR_PERIOD: cfg_reg.floor_period <= cfg_data[PERIOD_W-1:0];
                CFG_FLOOR_RATIO:  cfg_reg.floor_ratio  <= cfg_data[RATIO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    iad_front #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_segment_index (s_segment_index),
        .s_period_us     (s_period_us),
        .s_seg_threshold (s_seg_threshold),
        .s_seg_slope     (s_seg_slope),
        .s_seg_offset    (s_seg_offset),
        .push_valid      (push_valid),
        .push_cmd        (push_cmd),
        .push_ready      (push_ready)
    );

    iad_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    iad_back #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_cmd      (pop_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_delay_us   (m_delay_us),
        .m_over_limit (m_over_limit)
    );

endmodule

[src/iad_front.sv]
// input stage: takes items, drops out-of-range loads, hands commands to the queue
`timescale 1ns / 1ps

module iad_front import iad_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_operation,
    input  logic [IDX_W-1:0]         s_segment_index,
    input  logic [PERIOD_W-1:0]      s_period_us,
    input  logic [PERIOD_W-1:0]      s_seg_threshold,
    input  logic signed [COEF_W-1:0] s_seg_slope,
    input  logic signed [COEF_W-1:0] s_seg_offset,
    output logic                     push_valid,
    output cmd_t                     push_cmd,
    input  logic                     push_ready
);

    logic hold_valid_reg;
    logic hold_valid_next;
    logic keep_reg;
    cmd_t hold_cmd_reg;
    logic leave;
    logic accept;
    logic keep_in;

    // loads beyond the table are consumed without reaching the back end
    assign keep_in = (s_operation == OP_COMPUTE) || (int'(s_segment_index) < MAX_SEGMENTS);

    assign push_valid = hold_valid_reg && keep_reg;
    assign push_cmd   = hold_cmd_reg;
    assign leave      = hold_valid_reg && (!keep_reg || push_ready);
    assign s_ready    = !hold_valid_reg || leave;
    assign accept     = s_valid && s_ready;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        if (accept) begin
            hold_valid_next = 1'b1;
        end else if (leave) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            keep_reg               <= keep_in;
            hold_cmd_reg.is_load   <= (s_operation == OP_LOAD);
            hold_cmd_reg.index     <= s_segment_index;
            hold_cmd_reg.period    <= s_period_us;
            hold_cmd_reg.threshold <= s_seg_threshold;
            hold_cmd_reg.slope     <= s_seg_slope;
            hold_cmd_reg.offset    <= s_seg_offset;
        end
    end

endmodule

[src/iad_queue.sv]
// short command queue between the front and back ends
`timescale 1ns / 1ps

module iad_queue import iad_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_cmd,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_cmd
);

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t                 slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_next;
    logic [Q_CNT_W-1:0]   count_reg;
    logic [Q_CNT_W-1:0]   count_next;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[src/iad_back.sv]
// back end: segment memory, threshold scan, shared multiplier, clamp and result register
`timescale 1ns / 1ps

module iad_back import iad_pkg::*; #(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  cmd_t                pop_cmd,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DELAY_W-1:0]  m_delay_us,
    output logic                m_over_limit
);

    localparam int ADDR_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int IDX_MAX  = (1 << IDX_W) - 1;
    localparam int LAST_MAX = (MAX_SEGMENTS - 1 < IDX_MAX) ? MAX_SEGMENTS - 1 : IDX_MAX;
    localparam int SUM_HI   = DELAY_W + FRAC_W;
    localparam int FLR_HI   = DELAY_W + RATIO_FRAC_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]      threshold;
        logic signed [COEF_W-1:0] slope;
        logic signed [COEF_W-1:0] offset;
    } seg_t;

    seg_t                      seg_mem [MAX_SEGMENTS];
    seg_t                      rd_seg_reg;
    logic [ADDR_W-1:0]         rd_addr;
    logic [ADDR_W-1:0]         wr_addr;

    state_t                    state_reg;
    state_t                    state_next;
    logic [CNT_W-1:0]          scan_idx_reg;
    logic [CNT_W-1:0]          scan_idx_next;
    logic                      look_valid_reg;
    logic                      look_valid_next;
    logic [PERIOD_W-1:0]       period_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [COEF_W-1:0]  offset_reg;
    logic                      floor_sel_reg;
    logic                      red_reg;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    logic [DELAY_W-1:0]        m_delay_reg;
    logic                      m_over_reg;

    logic [IDX_W-1:0]          last_idx;
    logic                      take;
    logic                      mem_we;
    logic                      start;
    logic                      issue_ok;
    logic                      match;
    logic                      use_floor;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  product;
    logic signed [PROD_W-1:0]  off_ext;
    logic signed [PROD_W-1:0]  sum;
    logic [DELAY_W-1:0]        seg_delay;
    logic [DELAY_W-1:0]        flr_delay;
    logic [DELAY_W-1:0]        res_delay;
    logic                      out_free;

    assign last_idx = (cfg.seg_count > IDX_W'(LAST_MAX)) ? IDX_W'(LAST_MAX) : cfg.seg_count;

    assign pop_ready = (state_reg == ST_IDLE);
    assign take      = pop_valid && pop_ready;
    assign mem_we    = take && pop_cmd.is_load;
    assign start     = take && !pop_cmd.is_load;
    assign wr_addr   = ADDR_W'(pop_cmd.index);

    // the first entry is read while the compute command is popped
    assign rd_addr   = (state_reg == ST_SCAN) ? ADDR_W'(scan_idx_reg) : ADDR_W'(1);
    assign issue_ok  = (scan_idx_reg <= {1'b0, last_idx});

    assign match     = look_valid_reg && (period_reg >= rd_seg_reg.threshold);
    assign use_floor = (period_reg > cfg.floor_period);

    assign mul_a   = signed'({1'b0, period_reg});
    assign mul_b   = use_floor ? signed'({{(MUL_W - RATIO_W){1'b0}}, cfg.floor_ratio})
                               : signed'({rd_seg_reg.slope[COEF_W-1], rd_seg_reg.slope});
    assign product = mul_a * mul_b;

    // offset in the same Q.20 scale as the segment product
    assign off_ext = signed'({{(PROD_W - COEF_W - FRAC_W){offset_reg[COEF_W-1]}},
                              offset_reg, {FRAC_W{1'b0}}});
    assign sum     = prod_reg + off_ext;

    always_comb begin
        if (sum[PROD_W-1]) begin
            seg_delay = '0;
        end else if (|sum[PROD_W-2:SUM_HI]) begin
            seg_delay = '1;
        end else begin
            seg_delay = sum[SUM_HI-1:FRAC_W];
        end
        // floor product is never negative
        if (|prod_reg[PROD_W-1:FLR_HI]) begin
            flr_delay = '1;
        end else begin
            flr_delay = prod_reg[FLR_HI-1:RATIO_FRAC_W];
        end
        if (red_reg) begin
            res_delay = '0;
        end else if (floor_sel_reg) begin
            res_delay = flr_delay;
        end else begin
            res_delay = seg_delay;
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        look_valid_next = look_valid_reg;
        m_valid_next    = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next      = ST_SCAN;
                    scan_idx_next   = CNT_W'(2);
                    look_valid_next = (last_idx != '0);
                end
            end
            ST_SCAN: begin
                if (match || !look_valid_reg) begin
                    state_next = ST_FIN;
                end else begin
                    scan_idx_next   = scan_idx_reg + 1'b1;
                    look_valid_next = issue_ok;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            look_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            look_valid_reg <= look_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_idx_reg <= scan_idx_next;
        if (start) begin
            period_reg <= pop_cmd.period;
        end
        if (state_reg == ST_SCAN) begin
            if (match) begin
                prod_reg      <= product;
                offset_reg    <= rd_seg_reg.offset;
                floor_sel_reg <= use_floor;
                red_reg       <= 1'b0;
            end else if (!look_valid_reg) begin
                red_reg <= 1'b1;
            end
        end
        if (state_reg == ST_FIN && out_free) begin
            m_delay_reg <= res_delay;
            m_over_reg  <= red_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seg_mem[wr_addr] <= '{threshold: pop_cmd.threshold,
                                  slope:     pop_cmd.slope,
                                  offset:    pop_cmd.offset};
        end
        rd_seg_reg <= seg_mem[rd_addr];
    end

    assign m_valid      = m_valid_reg;
    assign m_delay_us   = m_delay_reg;
    assign m_over_limit = m_over_reg;

    // red line results always carry a zero delay
    a_red_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_over_reg) |-> (m_delay_reg == '0))
        else $error("over_limit result with nonzero delay");

    // a finished result waits in place while the output register is busy
    a_fin_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && !out_free) |=> (state_reg == ST_FIN && $stable(prod_reg)))
        else $error("pending result lost while output stalled");

    // a new result only appears out of the finish state
    a_out_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FIN))
        else $error("result register loaded outside finish state");

    // no command is taken while a compute is still scanning
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |=> !$past(take))
        else $error("command popped during scan");

endmodule

[verif/ignition_advance_delay_tb.sv]
// self-checking testbench for the ignition advance delay block
`timescale 1ns / 1ps

module ignition_advance_delay_tb;
    import iad_pkg::*;

    localparam int     CLK_HALF       = 6;
    localparam int     RESET_CYCLES   = 4;
    localparam int     SEG_DEPTH      = MAX_SEGMENTS_DEF;
    localparam int     DRAIN_CYCLES   = 40;
    localparam int     HOLDOFF_CYCLES = 400;
    localparam int     PHASES         = 8;
    localparam int     PHASE_ITEMS    = 250;
    localparam int     CYCLE_LIMIT    = 1000000;
    localparam int     MAX_REPORTS    = 10;
    localparam longint DELAY_MAX      = (longint'(1) << DELAY_W) - 1;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic               over_limit;
    } spark_t;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

    class delay_scoreboard;
        logic [IDX_W-1:0]         seg_count    = '0;
        logic [PERIOD_W-1:0]      floor_period = FLOOR_PERIOD_RST;
        logic [RATIO_W-1:0]       floor_ratio  = '0;
        logic [PERIOD_W-1:0]      threshold_tab[SEG_DEPTH];
        logic signed [COEF_W-1:0] slope_tab[SEG_DEPTH];
        logic signed [COEF_W-1:0] offset_tab[SEG_DEPTH];
        spark_t                   pending_delays[$];
        int                       fail_count = 0;

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SEG_COUNT:    seg_count    = data[IDX_W-1:0];
                CFG_FLOOR_PERIOD: floor_period = data[PERIOD_W-1:0];
                CFG_FLOOR_RATIO:  floor_ratio  = data[RATIO_W-1:0];
                default: ;
            endcase
        endfunction

        // first segment (longest period first) whose threshold the period reaches
        function spark_t spark_delay(logic [PERIOD_W-1:0] period);
            spark_t r;
            longint p;
            longint prod;
            int     j;
            r.delay      = '0;
            r.over_limit = 1'b1;
            p = longint'(period);
            for (j = 1; j <= seg_count && j < SEG_DEPTH; j++) begin
                if (period >= threshold_tab[j]) begin
                    r.over_limit = 1'b0;
                    if (period > floor_period)
                        prod = (p * floor_ratio) >> RATIO_FRAC_W;
                    else
                        prod = (p * slope_tab[j] + (longint'(offset_tab[j]) <<< FRAC_W))
                               >>> FRAC_W;
                    if (prod < 0)
                        r.delay = '0;
                    else if (prod > DELAY_MAX)
                        r.delay = DELAY_MAX[DELAY_W-1:0];
                    else
                        r.delay = prod[DELAY_W-1:0];
                    break;
                end
            end
            return r;
        endfunction

        function void note_input(cmd_t c);
            if (c.is_load == OP_LOAD) begin
                if (c.index < SEG_DEPTH) begin
                    threshold_tab[c.index] = c.threshold;
                    slope_tab[c.index]     = c.slope;
                    offset_tab[c.index]    = c.offset;
                end
            end else begin
                pending_delays.push_back(spark_delay(c.period));
            end
        endfunction

        function void report(string msg);
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        function void check_result(logic [DELAY_W-1:0] delay, logic over_limit);
            spark_t want;
            if (pending_delays.size() == 0) begin
                report($sformatf("unexpected result delay_us=%0d over_limit=%0b",
                                 delay, over_limit));
                return;
            end
            want = pending_delays.pop_front();
            if (delay !== want.delay)
                report($sformatf("delay_us expected %0d got %0d", want.delay, delay));
            if (over_limit !== want.over_limit)
                report($sformatf("over_limit expected %0b got %0b",
                                 want.over_limit, over_limit));
        endfunction
    endclass

    logic                     aclk            = 1'b0;
    logic                     aresetn         = 1'b0;
    logic                     cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index       = CFG_SEG_COUNT;
    logic [CFG_DATA_W-1:0]    cfg_data        = '0;
    logic                     s_valid         = 1'b0;
    logic                     s_ready;
    logic                     s_operation     = OP_COMPUTE;
    logic [IDX_W-1:0]         s_segment_index = '0;
    logic [PERIOD_W-1:0]      s_period_us     = '0;
    logic [PERIOD_W-1:0]      s_seg_threshold = '0;
    logic signed [COEF_W-1:0] s_seg_slope     = '0;
    logic signed [COEF_W-1:0] s_seg_offset    = '0;
    logic                     m_valid;
    logic                     m_ready         = 1'b0;
    logic [DELAY_W-1:0]       m_delay_us;
    logic                     m_over_limit;

    delay_scoreboard sb = new;

    int unsigned cycle_count  = 0;
    int          burst_left   = 0;
    int          holdoff_req  = 0;
    int          holdoff_seen = 0;
    int          holdoff_left = 0;
    int          stretch_left = 0;
    rx_mode_e    rx_mode      = RX_OPEN;

    ignition_advance_delay u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_segment_index (s_segment_index),
        .s_period_us     (s_period_us),
        .s_seg_threshold (s_seg_threshold),
        .s_seg_slope     (s_seg_slope),
        .s_seg_offset    (s_seg_offset),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_delay_us      (m_delay_us),
        .m_over_limit    (m_over_limit)
    );

    always #CLK_HALF aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** ignition_advance_delay: FAILED **");
            $finish;
        end
    end

    // result side: long hold-off on request, otherwise a changing stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_seen != holdoff_req) begin
            holdoff_seen <= holdoff_req;
            holdoff_left <= HOLDOFF_CYCLES;
            m_ready      <= 1'b0;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            m_ready      <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                rx_mode      <= rx_mode_e'($urandom_range(0, 2));
                stretch_left <= $urandom_range(8, 120);
            end else begin
                stretch_left <= stretch_left - 1;
            end
            case (rx_mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_RANDOM: m_ready <= 1'($urandom_range(0, 1));
                default:   m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_delay_us, m_over_limit);
    end

    function automatic cmd_t load_cmd(logic [IDX_W-1:0] idx, logic [PERIOD_W-1:0] thr,
                                      logic [COEF_W-1:0] slope, logic [COEF_W-1:0] offset);
        cmd_t c;
        c.is_load   = OP_LOAD;
        c.index     = idx;
        c.period    = PERIOD_W'($urandom);
        c.threshold = thr;
        c.slope     = slope;
        c.offset    = offset;
        return c;
    endfunction

    function automatic cmd_t compute_cmd(logic [PERIOD_W-1:0] period);
        cmd_t c;
        c.is_load   = OP_COMPUTE;
        c.index     = IDX_W'($urandom);
        c.period    = period;
        c.threshold = PERIOD_W'($urandom);
        c.slope     = COEF_W'($urandom);
        c.offset    = COEF_W'($urandom);
        return c;
    endfunction

    // mostly a descending curve and periods near its breakpoints, some noise
    function automatic cmd_t random_item();
        cmd_t c;
        int   j;
        int   pick;
        c = compute_cmd(PERIOD_W'($urandom));
        if ($urandom_range(0, 3) == 0) begin
            c.is_load = OP_LOAD;
            j    = int'(c.index);
            pick = $urandom_range(0, 9);
            if (pick < 7)
                c.threshold = PERIOD_W'((SEG_DEPTH - j) * 12000 + $urandom_range(0, 11999));
            else if (pick == 7)
                c.threshold = ($urandom_range(0, 1) != 0) ? '1 : '0;
            if ($urandom_range(0, 2) != 0) begin
                c.slope  = COEF_W'($urandom_range(0, 1 << 19));
                c.offset = COEF_W'($urandom_range(0, 4000) - 2000);
            end
        end else begin
            j    = $urandom_range(1, SEG_DEPTH - 1);
            pick = $urandom_range(0, 19);
            if (pick < 9)
                c.period = PERIOD_W'(sb.threshold_tab[j] + $urandom_range(0, 4) - 2);
            else if (pick < 11)
                c.period = PERIOD_W'(sb.floor_period + $urandom_range(0, 2) - 1);
            else if (pick < 17)
                c.period = PERIOD_W'($urandom_range(0, 250000));
            else if (pick == 17)
                c.period = ($urandom_range(0, 1) != 0) ? '1 : '0;
        end
        return c;
    endfunction

    task automatic send_item(input cmd_t c, input bit flood);
        int gap;
        s_valid         <= 1'b1;
        s_operation     <= c.is_load;
        s_segment_index <= c.index;
        s_period_us     <= c.period;
        s_seg_threshold <= c.threshold;
        s_seg_slope     <= c.slope;
        s_seg_offset    <= c.offset;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(c);
        if (burst_left > 0)
            burst_left--;
        if (!flood && burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(1, 24);
            s_valid   <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // loads still in the queue give no result, so allow extra cycles
    task automatic drain_results();
        s_valid <= 1'b0;
        while (sb.pending_delays.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic configure(input logic [IDX_W-1:0] count,
                             input logic [PERIOD_W-1:0] fperiod,
                             input logic [RATIO_W-1:0] fratio);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SEG_COUNT;
        cfg_data  <= CFG_DATA_W'(count);
        sb.write_reg(CFG_SEG_COUNT, CFG_DATA_W'(count));
        @(posedge aclk);
        cfg_index <= CFG_FLOOR_PERIOD;
        cfg_data  <= CFG_DATA_W'(fperiod);
        sb.write_reg(CFG_FLOOR_PERIOD, CFG_DATA_W'(fperiod));
        @(posedge aclk);
        cfg_index <= CFG_FLOOR_RATIO;
        cfg_data  <= CFG_DATA_W'(fratio);
        sb.write_reg(CFG_FLOOR_RATIO, CFG_DATA_W'(fratio));
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        int k;
        int ph;
        int i;
        logic [PERIOD_W-1:0] fperiod;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // reset setting has no segments: every compute is a red line
        send_item(compute_cmd('0), 1'b0);
        send_item(compute_cmd('1), 1'b0);
        // entry zero is written but never scanned
        send_item(load_cmd(IDX_W'(0), '0, 24'h800000, 24'h7FFFFF), 1'b0);
        send_item(load_cmd(IDX_W'(1), '1, 24'h7FFFFF, 24'h7FFFFF), 1'b0);
        send_item(load_cmd(IDX_W'(2), PERIOD_W'(200000), 24'h800000, 24'h800000), 1'b0);
        for (k = 3; k < SEG_DEPTH; k++)
            send_item(load_cmd(IDX_W'(k), PERIOD_W'(120000 - (k - 3) * 9000),
                               COEF_W'(k * 30000), COEF_W'(500 - k * 100)), 1'b0);

        // floor out of reach: saturation, negative clamp, breakpoint, red line
        configure(IDX_W'(SEG_DEPTH - 1), '1, '1);
        send_item(compute_cmd('1), 1'b0);
        send_item(compute_cmd(PERIOD_W'(250000)), 1'b0);
        send_item(compute_cmd(PERIOD_W'(60000)), 1'b0);
        send_item(compute_cmd(PERIOD_W'(12000)), 1'b0);
        send_item(compute_cmd(PERIOD_W'(11999)), 1'b0);

        // floor at zero: any match takes the floor ratio, red line still wins
        configure(IDX_W'(SEG_DEPTH - 1), '0, '1);
        send_item(compute_cmd(PERIOD_W'(50000)), 1'b0);
        send_item(compute_cmd('1), 1'b0);
        send_item(compute_cmd('0), 1'b0);

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: configure(IDX_W'(SEG_DEPTH - 1), '1, '0);
                1: configure('0, '0, '1);
                2: configure(IDX_W'(1), PERIOD_W'($urandom_range(20000, 200000)),
                             RATIO_W'($urandom));
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        fperiod = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    else
                        fperiod = PERIOD_W'($urandom_range(20000, 200000));
                    configure(IDX_W'($urandom_range(1, SEG_DEPTH - 1)), fperiod,
                              RATIO_W'($urandom));
                end
            endcase
            // output held off while input floods, so the block backs up
            if (ph == 3)
                holdoff_req++;
            for (i = 0; i < PHASE_ITEMS; i++)
                send_item(random_item(), ph == 3);
        end

        drain_results();
        if (sb.fail_count == 0)
            $display("** ignition_advance_delay: PASSED **");
        else
            $display("** ignition_advance_delay: FAILED **");
        $finish;
    end

endmodule
